// ----- rtl/core/refcounted_dedup_table_assert.svh -----
// Assertion macros for the table's RTL, used by rdt_datapath.
`ifndef REFCOUNTED_DEDUP_TABLE_ASSERT_SVH
`define REFCOUNTED_DEDUP_TABLE_ASSERT_SVH

// Checked at every rising edge while reset is released.
`define RDT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("refcounted_dedup_table assertion failed");

// Checked at every rising edge, reset included.
`define RDT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("refcounted_dedup_table assertion failed");

`endif

// ----- rtl/core/rdt_pkg.sv -----
package rdt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    localparam logic [63:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [31:0] GOLDEN_LO = GOLDEN[31:0];
    localparam logic [31:0] GOLDEN_HI = GOLDEN[63:32];
    localparam logic [31:0] REFS_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_BIND    = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NONE    = 2'd3
    } rdt_command_t;

    typedef enum logic [2:0] {
        ST_REUSED    = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_RELEASED  = 3'd5,
        ST_UNKNOWN   = 3'd6
    } rdt_status_t;

    typedef enum logic [2:0] {
        ACT_REUSE   = 3'd0,
        ACT_INSERT  = 3'd1,
        ACT_RELEASE = 3'd2,
        ACT_FOUND   = 3'd3,
        ACT_EMPTY   = 3'd4
    } rdt_action_t;

    typedef struct packed {
        logic load;
        logic mul0;
        logic mul1;
        logic mul2;
        logic key;
        logic scan;
        logic decide;
        logic use_tgt;
        logic apply;
    } rdt_ctl_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } rdt_stat_t;

endpackage

// ----- rtl/core/rdt_ctrl.sv -----
module rdt_ctrl
    import rdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rdt_stat_t st,
    output rdt_ctl_t  ctl
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL0   = 8'b0000_0010,
        S_MUL1   = 8'b0000_0100,
        S_MUL2   = 8'b0000_1000,
        S_KEY    = 8'b0001_0000,
        S_SCAN   = 8'b0010_0000,
        S_DECIDE = 8'b0100_0000,
        S_APPLY  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                ctl.mul0 = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                ctl.mul1 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                ctl.mul2 = 1'b1;
                state_next = S_KEY;
            end
            S_KEY:
            begin
                ctl.key = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctl.decide = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                ctl.use_tgt = 1'b1;
                ctl.apply = st.out_free;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ----- rtl/core/rdt_datapath.sv -----
`include "refcounted_dedup_table_assert.svh"

module rdt_datapath
    import rdt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rdt_ctl_t     ctl,
    output rdt_stat_t    st,
    input  logic [1:0]   command,
    input  logic [15:0]  tenant_id,
    input  logic [63:0]  semantic_hash,
    input  logic [63:0]  exact_hash,
    input  logic [63:0]  entry_id,
    input  logic [47:0]  byte_size,
    input  logic         share_scope,
    input  logic         semantic_fallback,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   status,
    output logic [63:0]  result_id,
    output logic [15:0]  owner_tenant,
    output logic         entry_scope,
    output logic [63:0]  entry_semantic,
    output logic [63:0]  entry_exact,
    output logic [47:0]  entry_bytes,
    output logic [31:0]  references
);

    logic                 slot_valid_reg [TABLE_ENTRIES];
    logic [63:0]          slot_id_reg [TABLE_ENTRIES];
    logic [63:0]          slot_sem_reg [TABLE_ENTRIES];
    logic [63:0]          slot_exact_reg [TABLE_ENTRIES];
    logic [63:0]          slot_key_reg [TABLE_ENTRIES];
    logic [15:0]          slot_tenant_reg [TABLE_ENTRIES];
    logic                 slot_scope_reg [TABLE_ENTRIES];
    logic [47:0]          slot_bytes_reg [TABLE_ENTRIES];
    logic [31:0]          slot_refs_reg [TABLE_ENTRIES];

    rdt_command_t         cmd_reg;
    logic [15:0]          tenant_reg;
    logic [63:0]          sem_reg;
    logic [63:0]          exact_reg;
    logic [63:0]          id_reg;
    logic [47:0]          bytes_reg;
    logic                 scope_reg;
    logic                 fallback_reg;

    logic [63:0]          acc_reg;
    logic [63:0]          sum_reg;
    logic [63:0]          key_reg;
    logic [63:0]          product;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;

    logic [IDX_W-1:0]     scan_idx_reg;
    logic                 key_hit_reg;
    logic [IDX_W-1:0]     key_idx_reg;
    logic [63:0]          key_best_reg;
    logic                 sem_hit_reg;
    logic [IDX_W-1:0]     sem_idx_reg;
    logic [63:0]          sem_best_reg;
    logic                 id_hit_reg;
    logic [IDX_W-1:0]     id_idx_reg;
    logic                 free_hit_reg;
    logic [IDX_W-1:0]     free_idx_reg;

    rdt_action_t          act_reg;
    rdt_action_t          act_next;
    rdt_status_t          dec_status_reg;
    rdt_status_t          dec_status_next;
    logic [IDX_W-1:0]     tgt_reg;
    logic [IDX_W-1:0]     tgt_next;

    logic [IDX_W-1:0]     rd_idx;
    logic                 e_valid;
    logic [63:0]          e_id;
    logic                 e_scope;
    logic                 visible;
    logic                 key_match;
    logic                 sem_match;
    logic [31:0]          new_refs;

    logic                 out_valid_reg;
    logic [2:0]           status_reg;
    logic [63:0]          result_id_reg;
    logic [15:0]          owner_reg;
    logic                 oscope_reg;
    logic [63:0]          osem_reg;
    logic [63:0]          oexact_reg;
    logic [47:0]          obytes_reg;
    logic [31:0]          orefs_reg;
    logic                 out_empty;

    assign rd_idx = ctl.use_tgt ? tgt_reg : scan_idx_reg;
    assign e_valid = slot_valid_reg[rd_idx];
    assign e_id = slot_id_reg[rd_idx];
    assign e_scope = slot_scope_reg[rd_idx];
    assign visible = (slot_tenant_reg[rd_idx] == tenant_reg)
        || (e_scope && (scope_reg || (cmd_reg == CMD_LOOKUP)));
    assign key_match = e_valid && visible && (slot_key_reg[rd_idx] == key_reg);
    assign sem_match = e_valid && visible && (slot_sem_reg[rd_idx] == sem_reg);

    assign st.scan_last = (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign st.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        mul_a = sem_reg[31:0];
        mul_b = GOLDEN_LO;
        if (ctl.mul1)
        begin
            mul_a = sem_reg[63:32];
        end
        else if (ctl.mul2)
        begin
            mul_b = GOLDEN_HI;
        end
    end

    assign product = 64'(mul_a) * 64'(mul_b);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= rdt_command_t'(command);
            tenant_reg <= tenant_id;
            sem_reg <= semantic_hash;
            exact_reg <= exact_hash;
            id_reg <= entry_id;
            bytes_reg <= byte_size;
            scope_reg <= share_scope;
            fallback_reg <= semantic_fallback;
        end
        if (ctl.mul0)
        begin
            acc_reg <= product;
            sum_reg <= exact_reg + GOLDEN;
        end
        if (ctl.mul1 || ctl.mul2)
        begin
            acc_reg[63:32] <= acc_reg[63:32] + product[31:0];
        end
        if (ctl.mul1)
        begin
            sum_reg <= sum_reg + {sem_reg[57:0], 6'd0};
        end
        if (ctl.mul2)
        begin
            sum_reg <= sum_reg + {2'd0, sem_reg[63:2]};
        end
        if (ctl.key)
        begin
            key_reg <= acc_reg ^ sum_reg;
        end
        if (ctl.decide)
        begin
            act_reg <= act_next;
            dec_status_reg <= dec_status_next;
            tgt_reg <= tgt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            key_hit_reg <= 1'b0;
            key_idx_reg <= '0;
            key_best_reg <= '0;
            sem_hit_reg <= 1'b0;
            sem_idx_reg <= '0;
            sem_best_reg <= '0;
            id_hit_reg <= 1'b0;
            id_idx_reg <= '0;
            free_hit_reg <= 1'b0;
            free_idx_reg <= '0;
        end
        else if (ctl.key)
        begin
            scan_idx_reg <= '0;
            key_hit_reg <= 1'b0;
            sem_hit_reg <= 1'b0;
            id_hit_reg <= 1'b0;
            free_hit_reg <= 1'b0;
        end
        else if (ctl.scan)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (key_match && (!key_hit_reg || (e_id < key_best_reg)))
            begin
                key_hit_reg <= 1'b1;
                key_idx_reg <= scan_idx_reg;
                key_best_reg <= e_id;
            end
            if (sem_match && (!sem_hit_reg || (e_id < sem_best_reg)))
            begin
                sem_hit_reg <= 1'b1;
                sem_idx_reg <= scan_idx_reg;
                sem_best_reg <= e_id;
            end
            if (e_valid && (e_id == id_reg) && !id_hit_reg)
            begin
                id_hit_reg <= 1'b1;
                id_idx_reg <= scan_idx_reg;
            end
            if (!e_valid && !free_hit_reg)
            begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= scan_idx_reg;
            end
        end
    end

    always_comb
    begin
        act_next = ACT_EMPTY;
        dec_status_next = ST_NOT_FOUND;
        tgt_next = free_idx_reg;
        unique case (cmd_reg)
            CMD_BIND:
            begin
                if (key_hit_reg)
                begin
                    act_next = ACT_REUSE;
                    dec_status_next = ST_REUSED;
                    tgt_next = key_idx_reg;
                end
                else if (id_hit_reg)
                begin
                    act_next = ACT_INSERT;
                    dec_status_next = ST_INSERTED;
                    tgt_next = id_idx_reg;
                end
                else if (free_hit_reg)
                begin
                    act_next = ACT_INSERT;
                    dec_status_next = ST_INSERTED;
                end
                else
                begin
                    dec_status_next = ST_FULL;
                end
            end
            CMD_LOOKUP:
            begin
                if (key_hit_reg)
                begin
                    act_next = ACT_FOUND;
                    dec_status_next = ST_FOUND;
                    tgt_next = key_idx_reg;
                end
                else if (fallback_reg && sem_hit_reg)
                begin
                    act_next = ACT_FOUND;
                    dec_status_next = ST_FOUND;
                    tgt_next = sem_idx_reg;
                end
            end
            CMD_RELEASE:
            begin
                if (id_hit_reg)
                begin
                    act_next = ACT_RELEASE;
                    dec_status_next = ST_RELEASED;
                    tgt_next = id_idx_reg;
                end
                else
                begin
                    dec_status_next = ST_UNKNOWN;
                end
            end
            default:
            begin
                act_next = ACT_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        new_refs = slot_refs_reg[rd_idx];
        case (act_reg)
            ACT_REUSE:
            begin
                if (slot_refs_reg[rd_idx] != REFS_MAX)
                begin
                    new_refs = slot_refs_reg[rd_idx] + 32'd1;
                end
            end
            ACT_INSERT:
            begin
                new_refs = 32'd1;
            end
            ACT_RELEASE:
            begin
                if (slot_refs_reg[rd_idx] != 32'd0)
                begin
                    new_refs = slot_refs_reg[rd_idx] - 32'd1;
                end
            end
            default:
            begin
                new_refs = slot_refs_reg[rd_idx];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.apply)
        begin
            if (act_reg == ACT_INSERT)
            begin
                slot_id_reg[tgt_reg] <= id_reg;
                slot_sem_reg[tgt_reg] <= sem_reg;
                slot_exact_reg[tgt_reg] <= exact_reg;
                slot_key_reg[tgt_reg] <= key_reg;
                slot_tenant_reg[tgt_reg] <= tenant_reg;
                slot_scope_reg[tgt_reg] <= scope_reg;
                slot_bytes_reg[tgt_reg] <= bytes_reg;
            end
            if ((act_reg == ACT_INSERT) || (act_reg == ACT_REUSE)
                || (act_reg == ACT_RELEASE))
            begin
                slot_refs_reg[tgt_reg] <= new_refs;
            end
            status_reg <= dec_status_reg;
            if (act_reg == ACT_INSERT)
            begin
                result_id_reg <= id_reg;
                owner_reg <= tenant_reg;
                oscope_reg <= scope_reg;
                osem_reg <= sem_reg;
                oexact_reg <= exact_reg;
                obytes_reg <= bytes_reg;
                orefs_reg <= new_refs;
            end
            else if (act_reg == ACT_EMPTY)
            begin
                result_id_reg <= '0;
                owner_reg <= '0;
                oscope_reg <= 1'b0;
                osem_reg <= '0;
                oexact_reg <= '0;
                obytes_reg <= '0;
                orefs_reg <= '0;
            end
            else
            begin
                result_id_reg <= e_id;
                owner_reg <= slot_tenant_reg[rd_idx];
                oscope_reg <= e_scope;
                osem_reg <= slot_sem_reg[rd_idx];
                oexact_reg <= slot_exact_reg[rd_idx];
                obytes_reg <= slot_bytes_reg[rd_idx];
                orefs_reg <= new_refs;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.apply)
            begin
                if (act_reg == ACT_INSERT)
                begin
                    slot_valid_reg[tgt_reg] <= 1'b1;
                end
                else if ((act_reg == ACT_RELEASE) && (new_refs == 32'd0))
                begin
                    slot_valid_reg[tgt_reg] <= 1'b0;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign result_id = result_id_reg;
    assign owner_tenant = owner_reg;
    assign entry_scope = oscope_reg;
    assign entry_semantic = osem_reg;
    assign entry_exact = oexact_reg;
    assign entry_bytes = obytes_reg;
    assign references = orefs_reg;

    assign out_empty = out_valid_reg && ((status_reg == ST_FULL)
        || (status_reg == ST_NOT_FOUND) || (status_reg == ST_UNKNOWN));

    `RDT_ASSERT(a_apply_into_free_slot, clk, rst_n, ctl.apply |-> (!out_valid_reg || out_ready))
    `RDT_ASSERT(a_apply_gives_word, clk, rst_n, ctl.apply |=> out_valid_reg)
    `RDT_ASSERT(a_empty_word_zero, clk, rst_n, out_empty |-> (orefs_reg == 32'd0))
    `RDT_ASSERT(a_insert_one_ref, clk, rst_n, (out_valid_reg && (status_reg == ST_INSERTED)) |-> (orefs_reg == 32'd1))

endmodule

// ----- rtl/core/refcounted_dedup_table.sv -----
// Deduplicating table of reference-counted entries keyed by a mix of a semantic and an exact
// hash. Each accepted word (bind, lookup or release) gives exactly one result word. One word is
// processed at a time: the multiply steps MUL0, MUL1 and MUL2 on a shared 32x32 multiplier and
// a KEY step build the 64-bit key, a scan visits one slot per cycle over all TABLE_ENTRIES slots,
// then a decide step chooses the action and a write-back step updates the slot and loads the
// output register; no new word is taken before that write-back. The result waits in an output
// register; the block holds its write-back while that register is full and out_ready is low.
module refcounted_dedup_table
    import rdt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   command,
    input  logic [15:0]  tenant_id,
    input  logic [63:0]  semantic_hash,
    input  logic [63:0]  exact_hash,
    input  logic [63:0]  entry_id,
    input  logic [47:0]  byte_size,
    input  logic         share_scope,
    input  logic         semantic_fallback,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   status,
    output logic [63:0]  result_id,
    output logic [15:0]  owner_tenant,
    output logic         entry_scope,
    output logic [63:0]  entry_semantic,
    output logic [63:0]  entry_exact,
    output logic [47:0]  entry_bytes,
    output logic [31:0]  references
);

    rdt_ctl_t  ctl;
    rdt_stat_t st;

    rdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .ctl      (ctl)
    );

    rdt_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .st                (st),
        .command           (command),
        .tenant_id         (tenant_id),
        .semantic_hash     (semantic_hash),
        .exact_hash        (exact_hash),
        .entry_id          (entry_id),
        .byte_size         (byte_size),
        .share_scope       (share_scope),
        .semantic_fallback (semantic_fallback),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .result_id         (result_id),
        .owner_tenant      (owner_tenant),
        .entry_scope       (entry_scope),
        .entry_semantic    (entry_semantic),
        .entry_exact       (entry_exact),
        .entry_bytes       (entry_bytes),
        .references        (references)
    );

endmodule
